FILE: rtl/swk_pkg.sv
// swk_pkg: shared types, constants and codes of the shortest walk unit
// no dependencies; imported by the interfaces and by every module of the block but swk_ram
`default_nettype none

package swk_pkg;

    localparam int SWK_MAX_VERTICES = 16;
    localparam int SWK_MAX_STEPS    = 255;

    localparam int SWK_IDX_W  = 4;
    localparam int SWK_WGT_W  = 16;
    localparam int SWK_DIST_W = 32;
    localparam int SWK_VC_W   = 5;
    localparam int SWK_SC_W   = 8;
    localparam int SWK_CFG_W  = 8;
    localparam int SWK_CIDX_W = 2;

    localparam logic [SWK_VC_W-1:0] SWK_VC_RESET = 5'd16;
    localparam logic [SWK_SC_W-1:0] SWK_SC_RESET = 8'd1;

    localparam logic [SWK_CIDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [SWK_CIDX_W-1:0] CFG_STEP_COUNT   = 2'd1;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    localparam logic signed [SWK_DIST_W-1:0] SWK_INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SWK_DIST_W-1:0] SWK_INT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                           vld;
        logic signed [SWK_DIST_W-1:0]   val;
    } t_cell;

    localparam t_cell CELL_INF  = '{vld: 1'b0, val: '0};
    localparam t_cell CELL_ZERO = '{vld: 1'b1, val: '0};

    typedef struct packed {
        logic                           no_edge;
        logic signed [SWK_WGT_W-1:0]    weight;
    } t_entry;

    localparam int SWK_ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic init;
        logic shift_acc;
        logic shift_cur;
        logic level_end;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/swk_in_if.sv
// swk_in_if: input channel of the shortest walk unit, valid/ready with payload
// depends on swk_pkg for field widths
`default_nettype none

interface swk_in_if import swk_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [SWK_IDX_W-1:0]         row;
    logic [SWK_IDX_W-1:0]         col;
    logic signed [SWK_WGT_W-1:0]  weight;
    logic                         no_edge;

    modport source (output valid, func, row, col, weight, no_edge, input ready);
    modport sink   (input valid, func, row, col, weight, no_edge, output ready);
endinterface

`default_nettype wire

FILE: rtl/swk_out_if.sv
// swk_out_if: result channel of the shortest walk unit, valid/ready with payload
// depends on swk_pkg for field widths
`default_nettype none

interface swk_out_if import swk_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic signed [SWK_DIST_W-1:0]  distance;

    modport source (output valid, found, distance, input ready);
    modport sink   (input valid, found, distance, output ready);
endinterface

`default_nettype wire

FILE: rtl/swk_ram.sv
// swk_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module swk_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/swk_minplus.sv
// swk_minplus: saturating add of path and edge weight, then minimum with accumulator
// depends on swk_pkg
`default_nettype none

module swk_minplus import swk_pkg::*; (
    input  wire t_cell  i_acc,
    input  wire t_cell  i_cur,
    input  wire t_entry i_entry,
    output t_cell       o_upd
);

    logic signed [SWK_DIST_W:0]   w_sum;
    logic signed [SWK_DIST_W-1:0] w_sat;

    always_comb begin
        w_sum = {i_cur.val[SWK_DIST_W-1], i_cur.val}
              + {{(SWK_DIST_W + 1 - SWK_WGT_W){i_entry.weight[SWK_WGT_W-1]}}, i_entry.weight};
        if (w_sum[SWK_DIST_W] != w_sum[SWK_DIST_W-1]) begin
            w_sat = w_sum[SWK_DIST_W] ? SWK_INT_MIN : SWK_INT_MAX;
        end else begin
            w_sat = w_sum[SWK_DIST_W-1:0];
        end

        o_upd = i_acc;
        if (i_cur.vld && !i_entry.no_edge) begin
            if (!i_acc.vld || (w_sat < i_acc.val)) begin
                o_upd.vld = 1'b1;
                o_upd.val = w_sat;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/swk_cell.sv
// swk_cell: one vertex slot of the ring, holds current level and accumulator values
// depends on swk_pkg
`default_nettype none

module swk_cell import swk_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_head,
    input  wire logic       i_last,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_cell      i_nbr_acc,
    input  wire t_cell      i_nbr_cur,
    input  wire t_cell      i_wrap_acc,
    input  wire t_cell      i_wrap_cur,
    output t_cell           o_acc,
    output t_cell           o_cur
);

    t_cell r_acc, n_acc;
    t_cell r_cur, n_cur;
    t_cell w_shift;

    always_comb begin
        n_acc   = r_acc;
        n_cur   = r_cur;
        w_shift = i_last ? i_wrap_acc : i_nbr_acc;
        if (i_ctrl.init) begin
            n_cur = i_head ? CELL_ZERO : CELL_INF;
            n_acc = CELL_INF;
        end else begin
            if (i_ctrl.shift_cur) begin
                n_cur = i_last ? i_wrap_cur : i_nbr_cur;
            end
            if (i_ctrl.shift_acc) begin
                if (i_ctrl.level_end) begin
                    n_cur = w_shift;
                    n_acc = CELL_INF;
                end else begin
                    n_acc = w_shift;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_cur <= n_cur;
    end

    assign o_acc = r_acc;
    assign o_cur = r_cur;

endmodule

`default_nettype wire

FILE: rtl/shortest_walk_k_edges_unit.sv
// shortest_walk_k_edges_unit: least weight walk from vertex 0 to the last vertex
// that takes exactly K steps. depends on swk_pkg, swk_in_if, swk_out_if, swk_ram,
// swk_cell and swk_minplus.
//
// usage
// - input channel i_item: func 0 writes one adjacency entry (row, col, weight,
//   no_edge) into the entry memory; func 1 starts a computation
// - result channel o_res: one transaction per computation with found and
//   distance (distance 0 when no walk exists); loads give no result
// - config port: vertex_count at index 0, step_count at index 1, written while
//   the block is idle
// - a computation reads the N*N entries once per step (N vertices in use, K steps),
//   then passes WAIT and DONE, straight to DONE when K is 0; the single read port of
//   the entry memory delivers one edge per cycle to the head of the cell ring
// - one transaction is worked on at a time; a load or a new computation is
//   taken while an earlier result still waits in the output register
// - when the receiver stalls, a finished computation waits before the output
//   register until it frees
// - reset returns to idle with vertex_count 16 and step_count 1; the entry
//   memory is not cleared and needs no clearing pass
`default_nettype none

module shortest_walk_k_edges_unit import swk_pkg::*; #(
    parameter int MAX_VERTICES = SWK_MAX_VERTICES,
    parameter int MAX_STEPS    = SWK_MAX_STEPS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    swk_in_if.sink                     i_item,
    swk_out_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [SWK_CIDX_W-1:0] i_cfg_idx,
    input  wire logic [SWK_CFG_W-1:0]  i_cfg_data
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;

    t_state               r_state, n_state;
    logic [VW-1:0]        r_ax, n_ax;
    logic [VW-1:0]        r_aj, n_aj;
    logic [SWK_SC_W-1:0]  r_lvl, n_lvl;
    logic                 r_rd_vld;
    logic                 r_last_j;
    logic                 r_last_x;
    logic [SWK_VC_W-1:0]  r_vertex_count;
    logic [SWK_SC_W-1:0]  r_step_count;
    logic                 r_out_vld, n_out_vld;
    logic                 r_found;
    logic signed [SWK_DIST_W-1:0] r_dist;

    logic                 w_in_acc;
    logic                 w_in_range;
    logic                 w_ram_we;
    logic                 w_issue;
    logic                 w_init;
    logic                 w_out_load;
    logic [VW-1:0]        w_last;
    logic [SWK_SC_W-1:0]  w_k;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [SWK_ENTRY_W-1:0] w_rdata;
    t_cell_ctrl           w_ctrl;
    t_cell                w_upd;
    t_cell                w_res;
    t_cell                w_acc [MAX_VERTICES];
    t_cell                w_cur [MAX_VERTICES];

    // clamped configuration
    always_comb begin
        if (r_vertex_count == '0) begin
            w_last = '0;
        end else if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            w_last = VW'(MAX_VERTICES - 1);
        end else begin
            w_last = VW'(r_vertex_count - 5'd1);
        end
        if (32'(r_step_count) > 32'(MAX_STEPS)) begin
            w_k = SWK_SC_W'(MAX_STEPS);
        end else begin
            w_k = r_step_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= SWK_VC_RESET;
            r_step_count   <= SWK_SC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[SWK_VC_W-1:0];
                CFG_STEP_COUNT:   r_step_count   <= i_cfg_data[SWK_SC_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_in_range = (32'(i_item.row) < 32'(MAX_VERTICES))
                     && (32'(i_item.col) < 32'(MAX_VERTICES));
    assign w_waddr    = {VW'(i_item.row), VW'(i_item.col)};
    assign w_raddr    = {r_ax, r_aj};
    assign i_item.ready = (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_ax       = r_ax;
        n_aj       = r_aj;
        n_lvl      = r_lvl;
        w_issue    = 1'b0;
        w_init     = 1'b0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        n_out_vld  = r_out_vld && !o_res.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_item.func == FUNC_LOAD) begin
                        w_ram_we = w_in_range;
                    end else begin
                        w_init  = 1'b1;
                        n_ax    = '0;
                        n_aj    = '0;
                        n_lvl   = '0;
                        n_state = (w_k == '0) ? ST_DONE : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                w_issue = 1'b1;
                if (r_aj == w_last) begin
                    n_aj = '0;
                    if (r_ax == w_last) begin
                        n_ax = '0;
                        if (r_lvl == w_k - 8'd1) begin
                            n_state = ST_WAIT;
                        end else begin
                            n_lvl = r_lvl + 8'd1;
                        end
                    end else begin
                        n_ax = r_ax + VW'(1);
                    end
                end else begin
                    n_aj = r_aj + VW'(1);
                end
            end
            ST_WAIT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    w_out_load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= w_issue;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_aj     <= n_aj;
        r_lvl    <= n_lvl;
        r_last_j <= (r_aj == w_last);
        r_last_x <= (r_ax == w_last);
        if (w_out_load) begin
            r_found <= w_res.vld;
            r_dist  <= w_res.vld ? w_res.val : '0;
        end
    end

    assign w_ctrl.init      = w_init;
    assign w_ctrl.shift_acc = r_rd_vld;
    assign w_ctrl.shift_cur = r_rd_vld && r_last_j;
    assign w_ctrl.level_end = r_rd_vld && r_last_j && r_last_x;

    swk_ram #(
        .WIDTH (SWK_ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_item.no_edge, i_item.weight}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    swk_minplus u_minplus (
        .i_acc   (w_acc[0]),
        .i_cur   (w_cur[0]),
        .i_entry (t_entry'(w_rdata)),
        .o_upd   (w_upd)
    );

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        t_cell w_nbr_acc;
        t_cell w_nbr_cur;
        if (i < MAX_VERTICES - 1) begin : g_mid
            assign w_nbr_acc = w_acc[i+1];
            assign w_nbr_cur = w_cur[i+1];
        end else begin : g_end
            assign w_nbr_acc = w_upd;
            assign w_nbr_cur = w_cur[0];
        end
        swk_cell u_cell (
            .i_clk      (i_clk),
            .i_head     (i == 0),
            .i_last     (VW'(i) == w_last),
            .i_ctrl     (w_ctrl),
            .i_nbr_acc  (w_nbr_acc),
            .i_nbr_cur  (w_nbr_cur),
            .i_wrap_acc (w_upd),
            .i_wrap_cur (w_cur[0]),
            .o_acc      (w_acc[i]),
            .o_cur      (w_cur[i])
        );
    end

    assign w_res = w_cur[w_last];

    assign o_res.valid    = r_out_vld;
    assign o_res.found    = r_found;
    assign o_res.distance = r_dist;

    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_RUN || r_state == ST_WAIT))
        else $error("edge read outside a computation");

    a_wait_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> ($past(r_state) == ST_RUN))
        else $error("drain cycle not preceded by the run");

    a_zero_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_item.func == FUNC_COMPUTE && w_k == '0) |=> (r_state == ST_DONE))
        else $error("zero step computation did not finish at once");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the done state");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking testbench of shortest_walk_k_edges_unit, with a directed table
// and random phases checked against a min-plus walk predictor
// depends on swk_pkg, swk_in_if, swk_out_if and the rtl of the unit
`default_nettype none

module tb;
    import swk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LOAD_SETTLE = 4;
    localparam int DIR_ROWS    = 28;
    localparam int HOLD_CYCLES = 600;

    localparam logic [SWK_CIDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [SWK_CIDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic                         func;
        logic [SWK_IDX_W-1:0]         row;
        logic [SWK_IDX_W-1:0]         col;
        logic signed [SWK_WGT_W-1:0]  weight;
        logic                         no_edge;
    } t_req;

    typedef struct {
        logic                          found;
        logic signed [SWK_DIST_W-1:0]  distance;
    } t_walk_res;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_RUN
    } t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [SWK_CIDX_W-1:0]   idx;
        logic [SWK_CFG_W-1:0]    data;
        t_req                    req;
        bit                      typed;
        t_walk_res               want;
    } t_dir_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SWK_CIDX_W-1:0] cfg_idx;
    logic [SWK_CFG_W-1:0]  cfg_data;

    swk_in_if  in_ch ();
    swk_out_if out_ch ();

    shortest_walk_k_edges_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (in_ch),
        .o_res      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow state of the unit
    t_entry                adj_shadow [SWK_MAX_VERTICES][SWK_MAX_VERTICES];
    bit                    adj_set    [SWK_MAX_VERTICES][SWK_MAX_VERTICES];
    logic [SWK_VC_W-1:0]   vc_shadow = SWK_VC_RESET;
    logic [SWK_SC_W-1:0]   sc_shadow = SWK_SC_RESET;
    t_walk_res             pending_walks [$];

    int       n_errors      = 0;
    int       cycle_cnt     = 0;
    int       snd_gap_pct   = 12;
    int       rcv_stall_pct = 73;
    int       rcv_hold      = 0;
    t_dir_row dir_rows [DIR_ROWS];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("shortest_walk_k_edges_unit test failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        n_errors++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    endtask

    function automatic int live_vertices();
        if (vc_shadow == 0) return 1;
        if (vc_shadow > SWK_MAX_VERTICES) return SWK_MAX_VERTICES;
        return int'(vc_shadow);
    endfunction

    // least weight of a walk 0 -> last vertex with exactly sc_shadow edges
    function automatic t_walk_res least_walk();
        t_cell     lvl [SWK_MAX_VERTICES];
        t_cell     nxt [SWK_MAX_VERTICES];
        int        nv;
        int        k;
        longint    s;
        t_walk_res res;
        nv = live_vertices();
        k  = (sc_shadow > SWK_MAX_STEPS) ? SWK_MAX_STEPS : int'(sc_shadow);
        foreach (lvl[i]) lvl[i] = CELL_INF;
        lvl[0] = CELL_ZERO;
        repeat (k) begin
            foreach (nxt[i]) nxt[i] = CELL_INF;
            for (int j = 0; j < nv; j++) begin
                for (int x = 0; x < nv; x++) begin
                    if (lvl[x].vld && !adj_shadow[x][j].no_edge) begin
                        s = longint'(lvl[x].val) + longint'(adj_shadow[x][j].weight);
                        if (s > longint'(SWK_INT_MAX)) s = longint'(SWK_INT_MAX);
                        if (s < longint'(SWK_INT_MIN)) s = longint'(SWK_INT_MIN);
                        if (!nxt[j].vld || s < longint'(nxt[j].val)) begin
                            nxt[j].vld = 1'b1;
                            nxt[j].val = s[SWK_DIST_W-1:0];
                        end
                    end
                end
            end
            lvl = nxt;
        end
        res.found    = lvl[nv-1].vld;
        res.distance = lvl[nv-1].vld ? lvl[nv-1].val : '0;
        return res;
    endfunction

    function automatic t_req roll_item(input int nv, input int run_pct);
        t_req r;
        r.func = ($urandom_range(99) < run_pct) ? FUNC_COMPUTE : FUNC_LOAD;
        if ($urandom_range(4) == 0) begin
            r.row = SWK_IDX_W'($urandom);
            r.col = SWK_IDX_W'($urandom);
        end else begin
            r.row = SWK_IDX_W'($urandom_range(nv - 1));
            r.col = SWK_IDX_W'($urandom_range(nv - 1));
        end
        case ($urandom_range(6))
            0:       r.weight = 16'sh8000;
            1:       r.weight = 16'sh7FFF;
            2:       r.weight = '0;
            3:       r.weight = 16'shFFFF;
            4:       r.weight = $signed(16'($urandom_range(200))) - 16'sd100;
            default: r.weight = SWK_WGT_W'($urandom);
        endcase
        r.no_edge = ($urandom_range(3) == 0);
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [SWK_CIDX_W-1:0] idx,
                                         input logic [SWK_CFG_W-1:0] data);
        t_dir_row d;
        d.kind  = ROW_CFG;
        d.idx   = idx;
        d.data  = data;
        d.typed = 1'b0;
        return d;
    endfunction

    function automatic t_dir_row load_row(input logic [SWK_IDX_W-1:0] r, input logic [SWK_IDX_W-1:0] c,
                                          input logic signed [SWK_WGT_W-1:0] w, input logic ne);
        t_dir_row d;
        d.kind        = ROW_LOAD;
        d.req.func    = FUNC_LOAD;
        d.req.row     = r;
        d.req.col     = c;
        d.req.weight  = w;
        d.req.no_edge = ne;
        d.typed       = 1'b0;
        return d;
    endfunction

    function automatic t_dir_row run_row(input bit typed, input logic found,
                                         input logic signed [SWK_DIST_W-1:0] want_dist);
        t_dir_row d;
        d.kind          = ROW_RUN;
        d.req           = roll_item(SWK_MAX_VERTICES, 0);
        d.req.func      = FUNC_COMPUTE;
        d.typed         = typed;
        d.want.found    = found;
        d.want.distance = want_dist;
        return d;
    endfunction

    task automatic push_item(input t_req r, input bit typed, input t_walk_res want);
        while ($urandom_range(99) < snd_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= r.func;
        in_ch.row     <= r.row;
        in_ch.col     <= r.col;
        in_ch.weight  <= r.weight;
        in_ch.no_edge <= r.no_edge;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        if (r.func == FUNC_LOAD) begin
            adj_shadow[r.row][r.col] = '{no_edge: r.no_edge, weight: r.weight};
            adj_set[r.row][r.col]    = 1'b1;
        end else begin
            pending_walks.push_back(typed ? want : least_walk());
        end
    endtask

    task automatic wait_results_in();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_walks.size() != 0) @(posedge clk);
    endtask

    task automatic settle_idle();
        wait_results_in();
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [SWK_CIDX_W-1:0] idx, input logic [SWK_CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VERTEX_COUNT) vc_shadow = data[SWK_VC_W-1:0];
        else if (idx == CFG_STEP_COUNT) sc_shadow = data;
    endtask

    task automatic run_phase(input logic [SWK_CFG_W-1:0] vc_data, input logic [SWK_CFG_W-1:0] steps,
                             input int n_items, input int run_pct, input int gap_pct,
                             input int stall_pct, input bit press);
        int        nv;
        bit        refill;
        t_req      q;
        t_walk_res none;
        none = '{found: 1'b0, distance: '0};
        settle_idle();
        snd_gap_pct   = gap_pct;
        rcv_stall_pct = stall_pct;
        write_reg(CFG_VERTEX_COUNT, vc_data);
        write_reg(CFG_STEP_COUNT, steps);
        nv     = live_vertices();
        refill = (nv * nv <= 64);
        for (int r = 0; r < nv; r++)
            for (int c = 0; c < nv; c++)
                if (!adj_set[r][c]) refill = 1'b1;
        // whole matrix in row order, random content
        if (refill) begin
            for (int r = 0; r < nv; r++) begin
                for (int c = 0; c < nv; c++) begin
                    q      = roll_item(nv, 0);
                    q.row  = SWK_IDX_W'(r);
                    q.col  = SWK_IDX_W'(c);
                    push_item(q, 1'b0, none);
                end
            end
        end
        for (int i = 0; i < n_items; i++) begin
            if (press && i == 10) begin
                // long receiver hold-off with back-to-back computations
                rcv_hold = HOLD_CYCLES;
                repeat (4) push_item(roll_item(nv, 100), 1'b0, none);
            end
            if (i == n_items / 2) wait_results_in();
            push_item(roll_item(nv, run_pct), 1'b0, none);
        end
    endtask

    // result side: random stalls, long hold-off on request, in-order check
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            t_walk_res want;
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_walks.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction found=%0b distance=%0d",
                                            out_ch.found, out_ch.distance));
                end else begin
                    want = pending_walks.pop_front();
                    if (out_ch.found !== want.found)
                        flag_mismatch($sformatf("found %0b, want %0b",
                                                out_ch.found, want.found));
                    if (out_ch.distance !== want.distance)
                        flag_mismatch($sformatf("distance %0d, want %0d",
                                                out_ch.distance, want.distance));
                end
            end
            if (rcv_hold > 0) begin
                rcv_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    initial begin
        int        tail;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.func    <= FUNC_LOAD;
        in_ch.row     <= '0;
        in_ch.col     <= '0;
        in_ch.weight  <= '0;
        in_ch.no_edge <= 1'b0;

        dir_rows = '{
            cfg_row(CFG_VERTEX_COUNT, 8'd2),
            load_row(4'd0, 4'd0, 16'sd5, 1'b0),
            load_row(4'd0, 4'd1, 16'sh8000, 1'b0),
            load_row(4'd1, 4'd0, 16'sh7FFF, 1'b0),
            load_row(4'd1, 4'd1, 16'sh7FFF, 1'b1),
            run_row(1'b1, 1'b1, -32'sd32768),      // step count after reset
            cfg_row(CFG_STEP_COUNT, 8'd0),
            run_row(1'b1, 1'b0, 32'sd0),           // zero steps, last vertex not 0
            cfg_row(CFG_VERTEX_COUNT, 8'd1),
            run_row(1'b1, 1'b1, 32'sd0),           // zero steps, single vertex
            cfg_row(CFG_VERTEX_COUNT, 8'd0),
            cfg_row(CFG_STEP_COUNT, 8'd3),
            run_row(1'b1, 1'b1, 32'sd15),          // vertex count zero runs as one
            cfg_row(CFG_VERTEX_COUNT, 8'd2),
            cfg_row(CFG_STEP_COUNT, 8'd2),
            run_row(1'b0, 1'b0, 32'sd0),
            cfg_row(CFG_SPARE_A, 8'hFF),
            cfg_row(CFG_SPARE_B, 8'h00),
            run_row(1'b0, 1'b0, 32'sd0),
            load_row(4'd0, 4'd1, 16'shFFFF, 1'b1),
            cfg_row(CFG_STEP_COUNT, 8'd1),
            run_row(1'b1, 1'b0, 32'sd0),           // last vertex unreachable
            load_row(4'd0, 4'd1, 16'sh5555, 1'b0),
            load_row(4'd1, 4'd1, 16'sh8000, 1'b0),
            cfg_row(CFG_STEP_COUNT, 8'd255),
            run_row(1'b0, 1'b0, 32'sd0),
            cfg_row(CFG_VERTEX_COUNT, 8'hE2),
            run_row(1'b0, 1'b0, 32'sd0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n]) begin
            case (dir_rows[n].kind)
                ROW_CFG: begin
                    settle_idle();
                    write_reg(dir_rows[n].idx, dir_rows[n].data);
                end
                default: begin
                    push_item(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);
                end
            endcase
        end

        run_phase(8'd4, 8'd6, 60, 20, 12, 73, 1'b1);
        run_phase(8'd16, 8'd2, 40, 20, 12, 73, 1'b0);
        run_phase(8'd0, 8'd255, 30, 20, 73, 12, 1'b0);
        run_phase(8'd31, 8'd1, 30, 25, 73, 12, 1'b0);
        run_phase(8'd16, 8'd255, 1, 100, 73, 12, 1'b0);
        run_phase(8'd5, 8'd0, 30, 25, 0, 0, 1'b0);
        repeat (4) begin
            run_phase({3'($urandom), 5'($urandom_range(16, 1))}, 8'($urandom_range(12)),
                      20, 25, 0, 0, 1'b0);
        end

        wait_results_in();
        tail = int'(sc_shadow) * live_vertices() * live_vertices() + 8;
        repeat (tail) @(posedge clk);

        if (n_errors == 0) begin
            $display("shortest_walk_k_edges_unit test passed");
        end else begin
            $display("shortest_walk_k_edges_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
